FILE: src/swl_pkg.sv
// Package for the soil/worm lattice update block.
// Holds beat structs, cell and mode codes, and register indexes.
// No dependencies.
`default_nettype none

package swl_pkg;

  localparam int SIDE_DEF  = 64;
  localparam int COORD_W   = 6;
  localparam int CELL_W    = 2;
  localparam int MODE_W    = 2;
  localparam int DRAW_W    = 16;
  localparam int PROB_W    = 17;
  localparam int CFG_IDX_W = 8;

  localparam logic [CELL_W-1:0] CELL_EMPTY    = 2'd0;
  localparam logic [CELL_W-1:0] CELL_NUTRIENT = 2'd1;
  localparam logic [CELL_W-1:0] CELL_SOIL     = 2'd2;
  localparam logic [CELL_W-1:0] CELL_WORM     = 2'd3;

  localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FILL      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEATH     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPRODUCE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPOSIT   = 8'd3;

  localparam logic [PROB_W-1:0] FILL_RST      = 17'd34734;
  localparam logic [PROB_W-1:0] DEATH_RST     = 17'd10486;
  localparam logic [PROB_W-1:0] REPRODUCE_RST = 17'd65536;
  localparam logic [PROB_W-1:0] DEPOSIT_RST   = 17'd65536;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [CELL_W-1:0]  cell_value;
    logic               axis;
    logic               direction;
    logic [DRAW_W-1:0]  draw_first;
    logic [DRAW_W-1:0]  draw_second;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0]  read_value;
    logic [CELL_W-1:0]  site_new;
    logic [COORD_W-1:0] neighbour_row;
    logic [COORD_W-1:0] neighbour_col;
    logic [CELL_W-1:0]  neighbour_new;
  } out_item_t;

endpackage

`default_nettype wire

FILE: src/soil_worm_lattice_update.sv
// Soil/worm lattice update: single-port lattice memory and its sequencer.
// Depends on swl_pkg.
//
// Sequence: the result strobe is registered in ST_EVAL and rises on entry to ST_WNB.
// Busy holds through ST_NB, ST_EVAL and ST_WNB, so a new item waits for the last; the
// single lattice memory port does site read, neighbour read, site write, neighbour write.
// Reset: state machine idles and the four thresholds take their defaults; the
// lattice is not cleared and holds nothing defined until written.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module soil_worm_lattice_update #(
  parameter int SIDE = swl_pkg::SIDE_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  output logic                                 busy,
  input  wire  swl_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  output swl_pkg::out_item_t                   out_data,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [swl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [swl_pkg::PROB_W-1:0]           cfg_data
);

  localparam int CW       = $clog2(SIDE);
  localparam int AW       = 2 * CW;
  localparam int DEPTH    = 1 << AW;
  localparam int IN_RANGE = 1 << swl_pkg::COORD_W;

  typedef enum logic [1:0] {ST_IDLE, ST_NB, ST_EVAL, ST_WNB} state_t;

  state_t state_r;

  logic [swl_pkg::PROB_W-1:0] fill_prob_r;
  logic [swl_pkg::PROB_W-1:0] death_prob_r;
  logic [swl_pkg::PROB_W-1:0] reproduce_prob_r;
  logic [swl_pkg::PROB_W-1:0] deposit_prob_r;

  logic [swl_pkg::MODE_W-1:0] mode_r;
  logic [CW-1:0]              row_r;
  logic [CW-1:0]              col_r;
  logic [swl_pkg::CELL_W-1:0] wval_r;
  logic                       axis_r;
  logic                       dir_r;
  logic [swl_pkg::DRAW_W-1:0] d1_r;
  logic [swl_pkg::DRAW_W-1:0] d2_r;
  logic [swl_pkg::CELL_W-1:0] site_old_r;
  logic                       nb_we_r;
  logic                       out_valid_r;
  swl_pkg::out_item_t         out_data_r;

  logic [swl_pkg::CELL_W-1:0] lattice_mem [DEPTH];
  logic [swl_pkg::CELL_W-1:0] mem_rdata_r;
  logic [AW-1:0]              mem_addr;
  logic                       mem_we;
  logic [swl_pkg::CELL_W-1:0] mem_wdata;

  logic [CW-1:0] mod_tbl [IN_RANGE];
  logic [CW-1:0] in_row_m;
  logic [CW-1:0] in_col_m;
  logic [CW-1:0] row_up, row_dn, col_up, col_dn;
  logic [CW-1:0] nb_row, nb_col;
  logic          accept;
  logic          is_update;
  logic          site_we;
  logic          nb_we_nxt;
  logic [swl_pkg::CELL_W-1:0] site_new_nxt;
  logic [swl_pkg::CELL_W-1:0] nb_new_nxt;
  logic [swl_pkg::CELL_W-1:0] behind;
  logic          hit_fill, hit_death, hit_repro, hit_depos;

  // reduce incoming coordinates modulo the lattice side
  for (genvar g = 0; g < IN_RANGE; g++) begin : g_mod
    assign mod_tbl[g] = CW'(g % SIDE);
  end

  assign in_row_m = mod_tbl[in_data.row];
  assign in_col_m = mod_tbl[in_data.col];

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy && !start;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign is_update = (mode_r == swl_pkg::MODE_UPDATE);

  assign row_up = (row_r == CW'(SIDE - 1)) ? '0 : row_r + CW'(1);
  assign row_dn = (row_r == '0) ? CW'(SIDE - 1) : row_r - CW'(1);
  assign col_up = (col_r == CW'(SIDE - 1)) ? '0 : col_r + CW'(1);
  assign col_dn = (col_r == '0) ? CW'(SIDE - 1) : col_r - CW'(1);
  assign nb_row = !axis_r ? (dir_r ? row_up : row_dn) : row_r;
  assign nb_col = axis_r ? (dir_r ? col_up : col_dn) : col_r;

  assign hit_fill  = {1'b0, d1_r} < fill_prob_r;
  assign hit_death = {1'b0, d1_r} < death_prob_r;
  assign hit_repro = {1'b0, d2_r} < reproduce_prob_r;
  assign hit_depos = {1'b0, d2_r} < deposit_prob_r;

  // cell left behind by a moving worm, keyed on the neighbour's old value
  always_comb begin
    behind = swl_pkg::CELL_EMPTY;
    case (mem_rdata_r)
      swl_pkg::CELL_NUTRIENT: begin
        if (hit_repro) behind = swl_pkg::CELL_WORM;
      end
      swl_pkg::CELL_SOIL: begin
        if (hit_depos) behind = swl_pkg::CELL_NUTRIENT;
      end
      swl_pkg::CELL_WORM:  behind = swl_pkg::CELL_WORM;
      default:             behind = swl_pkg::CELL_EMPTY;
    endcase
  end

  // evaluate the item; valid in ST_EVAL where mem_rdata_r holds the neighbour
  always_comb begin
    site_we      = 1'b0;
    nb_we_nxt    = 1'b0;
    site_new_nxt = site_old_r;
    case (mode_r)
      swl_pkg::MODE_WRITE: begin
        site_we      = 1'b1;
        site_new_nxt = wval_r;
      end
      swl_pkg::MODE_UPDATE: begin
        case (site_old_r)
          swl_pkg::CELL_EMPTY, swl_pkg::CELL_NUTRIENT: begin
            if (mem_rdata_r == swl_pkg::CELL_SOIL && hit_fill) begin
              site_we      = 1'b1;
              site_new_nxt = swl_pkg::CELL_SOIL;
            end
          end
          swl_pkg::CELL_WORM: begin
            site_we = 1'b1;
            if (hit_death) begin
              site_new_nxt = swl_pkg::CELL_EMPTY;
            end else begin
              site_new_nxt = behind;
              nb_we_nxt    = 1'b1;
            end
          end
          default: site_we = 1'b0;
        endcase
      end
      default: site_we = 1'b0;
    endcase
    nb_new_nxt = nb_we_nxt ? swl_pkg::CELL_WORM : mem_rdata_r;
  end

  // memory port: read site, read neighbour, write site, write neighbour
  always_comb begin
    mem_addr  = {row_r, col_r};
    mem_we    = 1'b0;
    mem_wdata = site_new_nxt;
    case (state_r)
      ST_IDLE: mem_addr = {in_row_m, in_col_m};
      ST_NB:   mem_addr = {nb_row, nb_col};
      ST_EVAL: begin
        mem_addr  = {row_r, col_r};
        mem_we    = site_we;
        mem_wdata = site_new_nxt;
      end
      ST_WNB: begin
        mem_addr  = {nb_row, nb_col};
        mem_we    = nb_we_r;
        mem_wdata = swl_pkg::CELL_WORM;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) lattice_mem[mem_addr] <= mem_wdata;
    mem_rdata_r <= lattice_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_prob_r      <= swl_pkg::FILL_RST;
      death_prob_r     <= swl_pkg::DEATH_RST;
      reproduce_prob_r <= swl_pkg::REPRODUCE_RST;
      deposit_prob_r   <= swl_pkg::DEPOSIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        swl_pkg::REG_FILL:      fill_prob_r      <= cfg_data;
        swl_pkg::REG_DEATH:     death_prob_r     <= cfg_data;
        swl_pkg::REG_REPRODUCE: reproduce_prob_r <= cfg_data;
        swl_pkg::REG_DEPOSIT:   deposit_prob_r   <= cfg_data;
        default:                fill_prob_r      <= fill_prob_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      nb_we_r     <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            mode_r  <= in_data.mode;
            row_r   <= in_row_m;
            col_r   <= in_col_m;
            wval_r  <= in_data.cell_value;
            axis_r  <= in_data.axis;
            dir_r   <= in_data.direction;
            d1_r    <= in_data.draw_first;
            d2_r    <= in_data.draw_second;
            state_r <= ST_NB;
          end
        end
        ST_NB: begin
          site_old_r <= mem_rdata_r;
          state_r    <= ST_EVAL;
        end
        ST_EVAL: begin
          nb_we_r                  <= nb_we_nxt;
          out_valid_r              <= 1'b1;
          out_data_r.read_value    <= site_old_r;
          out_data_r.site_new      <= site_new_nxt;
          out_data_r.neighbour_row <= is_update ? swl_pkg::COORD_W'(nb_row) : '0;
          out_data_r.neighbour_col <= is_update ? swl_pkg::COORD_W'(nb_col) : '0;
          out_data_r.neighbour_new <= is_update ? nb_new_nxt : swl_pkg::CELL_EMPTY;
          state_r                  <= ST_WNB;
        end
        ST_WNB: begin
          nb_we_r <= 1'b0;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result strobe missing three cycles after accept");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside an active item");

  a_nb_write_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WNB && nb_we_r) |-> (mode_r == swl_pkg::MODE_UPDATE))
    else $error("neighbour write outside update mode");

endmodule

`default_nettype wire

FILE: verif/tb_soil_worm_lattice_update.sv
`timescale 1ns / 100ps
// Self-checking testbench for soil_worm_lattice_update: directed table, then random
// write/update/read beats under several threshold settings. Needs swl_pkg and the block.

module tb_soil_worm_lattice_update;
  import swl_pkg::*;

  localparam int SIDE = SIDE_DEF;
  localparam int ITEMS_PER_PHASE = 270;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam logic [MODE_W-1:0] MODE_ALIAS_READ = 2'd3;
  localparam logic [PROB_W-1:0] PROB_ONE = 17'd65536;
  localparam logic [PROB_W-1:0] PROB_MAX = 17'h1FFFF;

  typedef logic [CELL_W-1:0] cell_t;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } plan_row_t;

  typedef struct {
    bit        typed;
    out_item_t res;
  } given_t;

  typedef struct {
    out_item_t res;
    bit        rv_known;
  } due_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_data;
  logic out_valid;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PROB_W-1:0] cfg_data;

  cell_t lattice [SIDE*SIDE];
  bit cell_known [SIDE*SIDE];
  bit loaded [SIDE*SIDE];
  logic [PROB_W-1:0] thr_fill, thr_death, thr_repro, thr_deposit;

  given_t given_q[$];
  due_t due_results[$];
  plan_row_t plan[$];

  int n_accepted, n_cfg, n_results, n_errors, n_settings;
  int n_writes, n_updates, n_reads;
  int idle_cycles;
  int win_r, win_c;

  soil_worm_lattice_update dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int wrap_coord(int v, bit up);
    return up ? (v + 1) % SIDE : (v + SIDE - 1) % SIDE;
  endfunction

  function automatic out_item_t advance_lattice(in_item_t it, output bit rv_known);
    int site, nb, nr, nc;
    cell_t site_old, nb_old, behind;
    out_item_t r;
    r = '0;
    site = (it.row % SIDE) * SIDE + (it.col % SIDE);
    site_old = lattice[site];
    rv_known = cell_known[site];
    if (it.mode == MODE_WRITE) begin
      lattice[site] = it.cell_value;
      cell_known[site] = 1'b1;
    end else if (it.mode == MODE_UPDATE) begin
      nr = it.axis ? int'(it.row) : wrap_coord(int'(it.row), it.direction);
      nc = it.axis ? wrap_coord(int'(it.col), it.direction) : int'(it.col);
      nb = nr * SIDE + nc;
      nb_old = lattice[nb];
      if (site_old == CELL_EMPTY || site_old == CELL_NUTRIENT) begin
        if (nb_old == CELL_SOIL && {1'b0, it.draw_first} < thr_fill) lattice[site] = CELL_SOIL;
      end else if (site_old == CELL_WORM) begin
        if ({1'b0, it.draw_first} < thr_death) begin
          lattice[site] = CELL_EMPTY;
        end else begin
          behind = CELL_EMPTY;
          case (nb_old)
            CELL_NUTRIENT: if ({1'b0, it.draw_second} < thr_repro) behind = CELL_WORM;
            CELL_SOIL: if ({1'b0, it.draw_second} < thr_deposit) behind = CELL_NUTRIENT;
            CELL_WORM: behind = CELL_WORM;
            default: behind = CELL_EMPTY;
          endcase
          lattice[nb] = CELL_WORM;
          lattice[site] = behind;
        end
      end
      r.neighbour_row = nr[COORD_W-1:0];
      r.neighbour_col = nc[COORD_W-1:0];
      r.neighbour_new = lattice[nb];
    end
    r.read_value = site_old;
    r.site_new = lattice[site];
    return r;
  endfunction

  task automatic compare_field(string what, logic [7:0] exp_v, logic [7:0] got_v);
    if (exp_v !== got_v) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin : track
    given_t g;
    due_t d;
    bit known;
    if (!rst_n) begin
      thr_fill = FILL_RST;
      thr_death = DEATH_RST;
      thr_repro = REPRODUCE_RST;
      thr_deposit = DEPOSIT_RST;
    end else begin
      if (start && !busy) begin
        g = given_q.pop_front();
        d.res = advance_lattice(in_data, known);
        d.rv_known = known;
        if (g.typed) begin
          d.res = g.res;
          d.rv_known = 1'b1;
        end
        due_results = {due_results, d};
        n_accepted++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FILL: thr_fill = cfg_data;
          REG_DEATH: thr_death = cfg_data;
          REG_REPRODUCE: thr_repro = cfg_data;
          REG_DEPOSIT: thr_deposit = cfg_data;
          default: ;
        endcase
        n_cfg++;
      end
      if (out_valid) begin
        n_results++;
        if (due_results.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        end else begin
          d = due_results.pop_front();
          if (d.rv_known)
            compare_field("read_value", 8'(d.res.read_value), 8'(out_data.read_value));
          compare_field("site_new", 8'(d.res.site_new), 8'(out_data.site_new));
          compare_field("neighbour_row", 8'(d.res.neighbour_row),
                        8'(out_data.neighbour_row));
          compare_field("neighbour_col", 8'(d.res.neighbour_col),
                        8'(out_data.neighbour_col));
          compare_field("neighbour_new", 8'(d.res.neighbour_new),
                        8'(out_data.neighbour_new));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t mk(logic [MODE_W-1:0] m, int r, int c, cell_t v, bit ax, bit dr,
                                  logic [DRAW_W-1:0] d1, logic [DRAW_W-1:0] d2);
    in_item_t it;
    it.mode = m;
    it.row = r[COORD_W-1:0];
    it.col = c[COORD_W-1:0];
    it.cell_value = v;
    it.axis = ax;
    it.direction = dr;
    it.draw_first = d1;
    it.draw_second = d2;
    return it;
  endfunction

  function automatic out_item_t res(cell_t rv, cell_t sn, int nr, int nc, cell_t nn);
    out_item_t r;
    r.read_value = rv;
    r.site_new = sn;
    r.neighbour_row = nr[COORD_W-1:0];
    r.neighbour_col = nc[COORD_W-1:0];
    r.neighbour_new = nn;
    return r;
  endfunction

  task automatic add_row(in_item_t it, bit typed, out_item_t r);
    plan_row_t p;
    p.item = it;
    p.typed = typed;
    p.res = r;
    plan = {plan, p};
  endtask

  function automatic logic [DRAW_W-1:0] pick_draw(logic [PROB_W-1:0] thr);
    logic [PROB_W-1:0] t;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: t = (thr == '0) ? thr : thr - PROB_W'(1);
      3: t = thr;
      default: return DRAW_W'($urandom);
    endcase
    return (t > 17'hFFFF) ? 16'hFFFF : t[DRAW_W-1:0];
  endfunction

  function automatic in_item_t gen_item();
    in_item_t it;
    int pick, r, c, nr, nc;
    if ($urandom_range(0, 3) != 0) begin
      r = (win_r + $urandom_range(0, 3)) % SIDE;
      c = (win_c + $urandom_range(0, 3)) % SIDE;
    end else begin
      r = $urandom_range(0, SIDE - 1);
      c = $urandom_range(0, SIDE - 1);
    end
    pick = $urandom_range(0, 99);
    it = mk(pick < 25 ? MODE_WRITE : pick < 80 ? MODE_UPDATE : pick < 95 ? MODE_READ
            : MODE_ALIAS_READ, r, c, cell_t'($urandom_range(0, 3)), 1'($urandom),
            1'($urandom),
            pick_draw($urandom_range(0, 1) ? thr_fill : thr_death),
            pick_draw($urandom_range(0, 1) ? thr_repro : thr_deposit));
    if (it.mode != MODE_WRITE && !loaded[r * SIDE + c]) begin
      it.mode = MODE_WRITE;
    end else if (it.mode == MODE_UPDATE) begin
      nr = it.axis ? r : wrap_coord(r, it.direction);
      nc = it.axis ? wrap_coord(c, it.direction) : c;
      if (!loaded[nr * SIDE + nc]) begin
        it.mode = MODE_WRITE;
        it.row = nr[COORD_W-1:0];
        it.col = nc[COORD_W-1:0];
      end
    end
    if (it.mode == MODE_WRITE) loaded[it.row * SIDE + it.col] = 1'b1;
    return it;
  endfunction

  task automatic send_item(in_item_t it, bit typed, out_item_t r);
    int want;
    given_t g;
    g.typed = typed;
    g.res = r;
    given_q = {given_q, g};
    case (it.mode)
      MODE_WRITE: n_writes++;
      MODE_UPDATE: n_updates++;
      default: n_reads++;
    endcase
    want = n_accepted + 1;
    start <= 1'b1;
    in_data <= it;
    do @(negedge clk); while (n_accepted != want);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (due_results.size() != 0 || busy !== 1'b0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic program_thresholds(logic [PROB_W-1:0] f, logic [PROB_W-1:0] dth,
                                    logic [PROB_W-1:0] rp, logic [PROB_W-1:0] dp,
                                    logic [CFG_IDX_W-1:0] spare_idx,
                                    logic [PROB_W-1:0] spare_data);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [PROB_W-1:0] val [5];
    int want;
    idx = '{REG_FILL, REG_DEATH, REG_REPRODUCE, REG_DEPOSIT, spare_idx};
    val = '{f, dth, rp, dp, spare_data};
    for (int i = 0; i < 5; i++) begin
      want = n_cfg + 1;
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(negedge clk); while (n_cfg != want);
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic run_random(int count, bit idle_on);
    int burst_left;
    burst_left = 0;
    for (int i = 0; i < count; i++) begin
      if (idle_on && burst_left <= 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      end
      send_item(gen_item(), 1'b0, '0);
      burst_left--;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    n_accepted = 0;
    n_cfg = 0;
    n_results = 0;
    n_errors = 0;
    n_settings = 1;
    n_writes = 0;
    n_updates = 0;
    n_reads = 0;
    idle_cycles = 0;
    for (int i = 0; i < SIDE * SIDE; i++) begin
      lattice[i] = CELL_EMPTY;
      cell_known[i] = 1'b0;
      loaded[i] = 1'b0;
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_row(mk(MODE_WRITE, 0, 0, CELL_WORM, 0, 0, 0, 0), 0, '0);
    add_row(mk(MODE_WRITE, 63, 0, CELL_NUTRIENT, 0, 0, 0, 0), 0, '0);
    add_row(mk(MODE_WRITE, 0, 63, CELL_SOIL, 0, 0, 0, 0), 0, '0);
    add_row(mk(MODE_WRITE, 0, 1, CELL_EMPTY, 0, 0, 0, 0), 0, '0);
    add_row(mk(MODE_WRITE, 63, 63, CELL_WORM, 0, 0, 0, 0), 0, '0);
    add_row(mk(MODE_WRITE, 62, 63, CELL_EMPTY, 0, 0, 0, 0), 0, '0);
    add_row(mk(MODE_WRITE, 62, 0, CELL_WORM, 0, 0, 0, 0), 0, '0);
    add_row(mk(MODE_READ, 0, 0, 0, 0, 0, 0, 0), 1, res(3, 3, 0, 0, 0));
    add_row(mk(MODE_ALIAS_READ, 63, 0, 3, 1, 1, '1, '1), 1, res(1, 1, 0, 0, 0));
    add_row(mk(MODE_UPDATE, 0, 0, 0, 0, 0, '1, 0), 1, res(3, 3, 63, 0, 3));
    add_row(mk(MODE_UPDATE, 0, 0, 0, 1, 0, '1, '1), 1, res(3, 1, 0, 63, 3));
    add_row(mk(MODE_UPDATE, 0, 0, 0, 1, 1, '1, '1), 1, res(1, 1, 0, 1, 0));
    add_row(mk(MODE_UPDATE, 0, 63, 0, 1, 1, 0, 0), 1, res(3, 0, 0, 0, 1));
    add_row(mk(MODE_WRITE, 0, 63, CELL_SOIL, 0, 0, 0, 0), 1, res(0, 2, 0, 0, 0));
    add_row(mk(MODE_UPDATE, 0, 0, 0, 1, 0, 0, '1), 1, res(1, 2, 0, 63, 2));
    add_row(mk(MODE_UPDATE, 0, 0, 0, 1, 1, 0, 0), 1, res(2, 2, 0, 1, 0));
    add_row(mk(MODE_UPDATE, 0, 1, 0, 1, 0, '1, 0), 1, res(0, 0, 0, 0, 2));
    add_row(mk(MODE_UPDATE, 63, 63, 0, 0, 0, '1, 0), 1, res(3, 0, 62, 63, 3));
    add_row(mk(MODE_UPDATE, 63, 0, 0, 0, 0, '1, 0), 1, res(3, 3, 62, 0, 3));
    add_row(mk(MODE_UPDATE, 63, 0, 0, 0, 1, '1, '1), 1, res(3, 1, 0, 0, 3));
    add_row(mk(MODE_READ, 0, 0, 3, 1, 1, '1, '1), 1, res(3, 3, 0, 0, 0));
    foreach (plan[i]) begin
      if (plan[i].item.mode == MODE_WRITE) loaded[plan[i].item.row * SIDE + plan[i].item.col] = 1'b1;
      send_item(plan[i].item, plan[i].typed, plan[i].res);
    end
    settle();

    for (int p = 0; p < 7; p++) begin
      case (p)
        1: program_thresholds('0, '0, '0, '0, 8'd4, PROB_W'($urandom_range(0, 131071)));
        2: program_thresholds(PROB_ONE, PROB_ONE, PROB_ONE, PROB_ONE, 8'd17, PROB_MAX);
        3: program_thresholds(PROB_MAX, PROB_MAX, PROB_MAX, PROB_MAX, 8'd255, '0);
        4, 5: program_thresholds(PROB_W'($urandom_range(0, 65536)),
                                 PROB_W'($urandom_range(0, 65536)),
                                 PROB_W'($urandom_range(0, 65536)),
                                 PROB_W'($urandom_range(0, 65536)),
                                 CFG_IDX_W'($urandom_range(4, 255)),
                                 PROB_W'($urandom_range(0, 131071)));
        6: program_thresholds(FILL_RST, DEATH_RST, REPRODUCE_RST, DEPOSIT_RST, 8'd128, '0);
        default: ;
      endcase
      win_r = (p == 0) ? 62 : $urandom_range(0, SIDE - 1);
      win_c = (p == 0) ? 62 : $urandom_range(0, SIDE - 1);
      run_random(ITEMS_PER_PHASE, p != 2 && p != 5);
      settle();
    end

    if (given_q.size() != 0 || due_results.size() != 0) begin
      n_errors++;
      $display("%0t: %0d results still pending at end, expected 0", $time, due_results.size());
    end
    $display("ran %0d beats (%0d writes, %0d updates, %0d reads), %0d results compared",
             n_accepted, n_writes, n_updates, n_reads, n_results);
    $display("covered %0d threshold settings over %0d register writes", n_settings, n_cfg);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
